// ===== rtl/ecc_pkg.sv =====
// Package for the collective elevator controller: word types, codes and defaults.
// Used by ecc_step and elevator_collective_control_unit; depends on nothing.
`default_nettype none
package ecc_pkg;

    localparam int FLOORS_DEFAULT = 9;

    localparam logic [1:0] KIND_DOWN = 2'd0;
    localparam logic [1:0] KIND_CAR  = 2'd1;
    localparam logic [1:0] KIND_UP   = 2'd2;

    localparam logic [1:0] HEAD_IDLE = 2'd0;
    localparam logic [1:0] HEAD_UP   = 2'd1;
    localparam logic [1:0] HEAD_DOWN = 2'd2;

    localparam logic [1:0] ACT_IDLE  = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_MOVE  = 2'd2;
    localparam logic [1:0] ACT_PRESS = 2'd3;

    localparam logic OP_PRESS = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [1:0] button_kind;
        logic [3:0] button_floor;
    } ecc_in_t;

    typedef struct packed {
        logic [3:0] car_position;
        logic [1:0] heading;
        logic [1:0] action;
    } ecc_out_t;

endpackage
`default_nettype wire

// ===== rtl/ecc_step.sv =====
// Next-state logic of the collective elevator controller for one input word.
// Purely combinational; depends on ecc_pkg for codes and word types.
`default_nettype none
module ecc_step #(
    parameter int FLOORS = ecc_pkg::FLOORS_DEFAULT,
    localparam int FW = $clog2(FLOORS)
) (
    input  wire ecc_pkg::ecc_in_t  in_word,
    input  wire logic [FLOORS-1:0] down_q,
    input  wire logic [FLOORS-1:0] car_q,
    input  wire logic [FLOORS-1:0] up_q,
    input  wire logic [FW-1:0]     floor_q,
    input  wire logic [1:0]        dir_q,
    output logic [FLOORS-1:0]      down_n,
    output logic [FLOORS-1:0]      car_n,
    output logic [FLOORS-1:0]      up_n,
    output logic [FW-1:0]          floor_n,
    output logic [1:0]             dir_n,
    output ecc_pkg::ecc_out_t      out_word
);

    logic [FLOORS-1:0] any_v;
    logic [FLOORS-1:0] at_f;
    logic [FLOORS-1:0] above_m;
    logic [FLOORS-1:0] below_m;
    logic [FLOORS-1:0] press_hit;
    logic [6:0]        press_floor;
    logic              press_ok;
    logic              any_call;
    logic              any_above;
    logic              any_below;
    logic              car_here;
    logic              down_here;
    logic              up_here;
    logic              ahead;
    logic              behind;
    logic              same_hall;
    logic              opp_hall;
    logic [1:0]        head;
    logic [1:0]        action;
    logic [6:0]        pos_ext;

    assign press_floor = 7'(in_word.button_floor);
    assign press_ok    = press_floor < 7'(FLOORS);

    always_comb begin
        for (int i = 0; i < FLOORS; i++) begin
            at_f[i]      = floor_q == FW'(i);
            above_m[i]   = FW'(i) > floor_q;
            below_m[i]   = FW'(i) < floor_q;
            press_hit[i] = press_floor == 7'(i);
        end
    end

    assign any_v     = down_q | car_q | up_q;
    assign any_call  = |any_v;
    assign any_above = |(any_v & above_m);
    assign any_below = |(any_v & below_m);
    assign car_here  = |(car_q & at_f);
    assign down_here = |(down_q & at_f);
    assign up_here   = |(up_q & at_f);

    always_comb begin
        down_n  = down_q;
        car_n   = car_q;
        up_n    = up_q;
        floor_n = floor_q;
        dir_n   = dir_q;
        action  = ecc_pkg::ACT_IDLE;
        head    = dir_q;
        ahead   = 1'b0;
        behind  = 1'b0;
        same_hall = 1'b0;
        opp_hall  = 1'b0;
        if (in_word.op == ecc_pkg::OP_PRESS) begin
            if (press_ok) begin
                case (in_word.button_kind)
                    ecc_pkg::KIND_DOWN: begin
                        down_n = down_q | press_hit;
                        action = ecc_pkg::ACT_PRESS;
                    end
                    ecc_pkg::KIND_CAR: begin
                        car_n  = car_q | press_hit;
                        action = ecc_pkg::ACT_PRESS;
                    end
                    ecc_pkg::KIND_UP: begin
                        up_n   = up_q | press_hit;
                        action = ecc_pkg::ACT_PRESS;
                    end
                    default: begin
                        action = ecc_pkg::ACT_IDLE;
                    end
                endcase
            end
        end else if (!any_call) begin
            dir_n = ecc_pkg::HEAD_IDLE;
        end else if (dir_q != ecc_pkg::HEAD_UP && dir_q != ecc_pkg::HEAD_DOWN
                     && !any_above && !any_below) begin
            // Calls only at the idle car's floor: serve all of them and stay idle.
            dir_n  = ecc_pkg::HEAD_IDLE;
            down_n = down_q & ~at_f;
            car_n  = car_q & ~at_f;
            up_n   = up_q & ~at_f;
            action = ecc_pkg::ACT_STOP;
        end else begin
            if (dir_q != ecc_pkg::HEAD_UP && dir_q != ecc_pkg::HEAD_DOWN) begin
                head = any_above ? ecc_pkg::HEAD_UP : ecc_pkg::HEAD_DOWN;
            end else begin
                ahead     = (dir_q == ecc_pkg::HEAD_UP) ? any_above : any_below;
                behind    = (dir_q == ecc_pkg::HEAD_UP) ? any_below : any_above;
                same_hall = (dir_q == ecc_pkg::HEAD_UP) ? up_here : down_here;
                opp_hall  = (dir_q == ecc_pkg::HEAD_UP) ? down_here : up_here;
                if (!ahead && (behind || (!same_hall && opp_hall))) begin
                    head = (dir_q == ecc_pkg::HEAD_UP) ? ecc_pkg::HEAD_DOWN
                                                       : ecc_pkg::HEAD_UP;
                end
            end
            dir_n = head;
            if (car_here || (head == ecc_pkg::HEAD_UP ? up_here : down_here)) begin
                car_n = car_q & ~at_f;
                if (head == ecc_pkg::HEAD_UP) begin
                    up_n = up_q & ~at_f;
                end else begin
                    down_n = down_q & ~at_f;
                end
                action = ecc_pkg::ACT_STOP;
            end else begin
                if (head == ecc_pkg::HEAD_UP) begin
                    if (floor_q != FW'(FLOORS - 1)) begin
                        floor_n = floor_q + FW'(1);
                    end
                end else if (floor_q != FW'(0)) begin
                    floor_n = floor_q - FW'(1);
                end
                action = ecc_pkg::ACT_MOVE;
            end
        end
    end

    assign pos_ext               = 7'(floor_n);
    assign out_word.car_position = pos_ext[3:0];
    assign out_word.heading      = dir_n;
    assign out_word.action       = action;

endmodule
`default_nettype wire

// ===== rtl/elevator_collective_control_unit.sv =====
// Collective elevator controller: top level with handshake, state and result register.
// Depends on ecc_pkg and ecc_step.
// The result word is registered and appears on m_data the cycle after acceptance.
// One word per cycle unless m_ready stalls a held result; step logic is single-pass.
// Synchronous active-low reset clears all calls, puts the car at floor 0 and idles it.
`default_nettype none
module elevator_collective_control_unit #(
    parameter int FLOORS = ecc_pkg::FLOORS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ecc_pkg::ecc_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ecc_pkg::ecc_out_t      m_data
);

    localparam int FW = $clog2(FLOORS);

    logic [FLOORS-1:0]  down_reg;
    logic [FLOORS-1:0]  car_reg;
    logic [FLOORS-1:0]  up_reg;
    logic [FW-1:0]      floor_reg;
    logic [1:0]         dir_reg;
    logic               m_valid_reg;
    ecc_pkg::ecc_out_t  m_data_reg;

    logic [FLOORS-1:0]  down_next;
    logic [FLOORS-1:0]  car_next;
    logic [FLOORS-1:0]  up_next;
    logic [FW-1:0]      floor_next;
    logic [1:0]         dir_next;
    ecc_pkg::ecc_out_t  m_data_next;
    logic               accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ecc_step #(
        .FLOORS(FLOORS)
    ) u_step (
        .in_word (s_data),
        .down_q  (down_reg),
        .car_q   (car_reg),
        .up_q    (up_reg),
        .floor_q (floor_reg),
        .dir_q   (dir_reg),
        .down_n  (down_next),
        .car_n   (car_next),
        .up_n    (up_next),
        .floor_n (floor_next),
        .dir_n   (dir_next),
        .out_word(m_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg    <= '0;
            car_reg     <= '0;
            up_reg      <= '0;
            floor_reg   <= '0;
            dir_reg     <= ecc_pkg::HEAD_IDLE;
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            down_reg    <= down_next;
            car_reg     <= car_next;
            up_reg      <= up_next;
            floor_reg   <= floor_next;
            dir_reg     <= dir_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_elevator_collective_control_unit.sv =====
// Self-checking testbench for elevator_collective_control_unit: presses and ticks go in,
// and each result word is compared against a behavioural car and call-latch model.
// Depends on ecc_pkg and the RTL of the controller; needs nothing else.
`timescale 1ns / 100ps
module tb_elevator_collective_control_unit;

    localparam int NFLOORS = ecc_pkg::FLOORS_DEFAULT;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ecc_pkg::ecc_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ecc_pkg::ecc_out_t m_data;

    logic [3*NFLOORS-1:0] model_calls;
    logic [3:0] model_floor;
    logic [1:0] model_head;

    ecc_pkg::ecc_out_t expected_car_q[$];
    int fault_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int cycle_count = 0;
    int hold_request = 0;
    bit sender_gaps_on = 1'b1;
    bit receiver_gaps_on = 1'b1;

    elevator_collective_control_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run exceeded %0d cycles.", CYCLE_LIMIT);
            $display("tb_elevator_collective_control_unit: errors");
            $finish;
        end
    end

    function automatic bit latched(input logic [1:0] kind, input int f);
        return model_calls[int'(kind) * NFLOORS + f];
    endfunction

    function automatic bit floor_has_call(input int f);
        return latched(ecc_pkg::KIND_DOWN, f) || latched(ecc_pkg::KIND_CAR, f) ||
               latched(ecc_pkg::KIND_UP, f);
    endfunction

    function automatic bit calls_above(input int f);
        bit found;
        found = 1'b0;
        for (int i = f + 1; i < NFLOORS; i++) found |= floor_has_call(i);
        return found;
    endfunction

    function automatic bit calls_below(input int f);
        bit found;
        found = 1'b0;
        for (int i = 0; i < f && i < NFLOORS; i++) found |= floor_has_call(i);
        return found;
    endfunction

    function automatic bit calls_ahead(input logic [1:0] head, input int f);
        return (head == ecc_pkg::HEAD_UP) ? calls_above(f) : calls_below(f);
    endfunction

    function automatic logic [1:0] hall_kind_for(input logic [1:0] head);
        return (head == ecc_pkg::HEAD_UP) ? ecc_pkg::KIND_UP : ecc_pkg::KIND_DOWN;
    endfunction

    function automatic logic [1:0] car_tick();
        int f;
        logic [1:0] opp;
        logic [1:0] hk;
        f = int'(model_floor);
        if (model_calls == '0) begin
            model_head = ecc_pkg::HEAD_IDLE;
            return ecc_pkg::ACT_IDLE;
        end
        if (model_head != ecc_pkg::HEAD_UP && model_head != ecc_pkg::HEAD_DOWN) begin
            if (calls_above(f)) begin
                model_head = ecc_pkg::HEAD_UP;
            end else if (calls_below(f)) begin
                model_head = ecc_pkg::HEAD_DOWN;
            end else begin
                model_head = ecc_pkg::HEAD_IDLE;
                model_calls[int'(ecc_pkg::KIND_DOWN) * NFLOORS + f] = 1'b0;
                model_calls[int'(ecc_pkg::KIND_CAR) * NFLOORS + f] = 1'b0;
                model_calls[int'(ecc_pkg::KIND_UP) * NFLOORS + f] = 1'b0;
                return ecc_pkg::ACT_STOP;
            end
        end else if (!calls_ahead(model_head, f)) begin
            opp = (model_head == ecc_pkg::HEAD_UP) ? ecc_pkg::HEAD_DOWN : ecc_pkg::HEAD_UP;
            if (calls_ahead(opp, f)) begin
                model_head = opp;
            end else if (!latched(hall_kind_for(model_head), f) &&
                         latched(hall_kind_for(opp), f)) begin
                model_head = opp;
            end
        end
        hk = hall_kind_for(model_head);
        if (latched(ecc_pkg::KIND_CAR, f) || latched(hk, f)) begin
            model_calls[int'(ecc_pkg::KIND_CAR) * NFLOORS + f] = 1'b0;
            model_calls[int'(hk) * NFLOORS + f] = 1'b0;
            return ecc_pkg::ACT_STOP;
        end
        if (model_head == ecc_pkg::HEAD_UP) begin
            if (f + 1 < NFLOORS) model_floor = model_floor + 4'd1;
        end else begin
            if (f > 0) model_floor = model_floor - 4'd1;
        end
        return ecc_pkg::ACT_MOVE;
    endfunction

    function automatic ecc_pkg::ecc_out_t predict_car_step(input ecc_pkg::ecc_in_t w);
        ecc_pkg::ecc_out_t r;
        logic [1:0] act;
        if (w.op == ecc_pkg::OP_PRESS) begin
            if (w.button_kind != KIND_NONE && int'(w.button_floor) < NFLOORS) begin
                model_calls[int'(w.button_kind) * NFLOORS + int'(w.button_floor)] = 1'b1;
                act = ecc_pkg::ACT_PRESS;
            end else begin
                act = ecc_pkg::ACT_IDLE;
            end
        end else begin
            act = car_tick();
        end
        r.car_position = model_floor;
        r.heading = model_head;
        r.action = act;
        return r;
    endfunction

    // Entered and left just after a rising edge; the word is accepted at the last edge.
    task automatic send_word(input ecc_pkg::ecc_in_t w);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        expected_car_q.push_back(predict_car_step(w));
        words_sent++;
    endtask

    task automatic press(input logic [1:0] kind, input logic [3:0] fl);
        ecc_pkg::ecc_in_t w;
        w.op = ecc_pkg::OP_PRESS;
        w.button_kind = kind;
        w.button_floor = fl;
        send_word(w);
    endtask

    task automatic tick(input int count);
        ecc_pkg::ecc_in_t w;
        for (int i = 0; i < count; i++) begin
            w.op = ecc_pkg::OP_TICK;
            w.button_kind = 2'($urandom_range(0, 3));
            w.button_floor = 4'($urandom_range(0, 15));
            send_word(w);
        end
    endtask

    initial begin
        int gap;
        forever begin
            if (hold_request > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (hold_request - 1) @(negedge aclk);
                hold_request = 0;
            end
            gap = receiver_gaps_on ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        ecc_pkg::ecc_out_t exp_word;
        if (aresetn && m_valid && m_ready) begin
            if (expected_car_q.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("Unexpected result word %p at cycle %0d.", m_data, cycle_count);
            end else begin
                exp_word = expected_car_q.pop_front();
                results_checked++;
                if (m_data.car_position !== exp_word.car_position ||
                    m_data.heading !== exp_word.heading ||
                    m_data.action !== exp_word.action) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("Mismatch at cycle %0d: expected %p, got %p.",
                                 cycle_count, exp_word, m_data);
                end
            end
        end
    end

    task automatic test_ignored_presses();
        tick(1);
        press(KIND_NONE, 4'd0);
        press(ecc_pkg::KIND_DOWN, 4'd15);
        press(ecc_pkg::KIND_UP, 4'd9);
    endtask

    task automatic test_idle_same_floor();
        press(ecc_pkg::KIND_CAR, 4'd0);
        press(ecc_pkg::KIND_UP, 4'd0);
        press(ecc_pkg::KIND_DOWN, 4'd0);
        tick(2);
    endtask

    task automatic test_run_to_top();
        press(ecc_pkg::KIND_CAR, 4'd8);
        press(ecc_pkg::KIND_CAR, 4'd8);
        press(ecc_pkg::KIND_UP, 4'd4);
        tick(10);
    endtask

    task automatic test_reverse_at_floor();
        press(ecc_pkg::KIND_DOWN, 4'd8);
        tick(2);
    endtask

    task automatic test_random_traffic(input int count);
        ecc_pkg::ecc_in_t w;
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            w.op = ecc_pkg::OP_TICK;
            w.button_kind = 2'($urandom_range(0, 3));
            w.button_floor = 4'($urandom_range(0, 15));
            if (roll < 45) begin
                w.op = ecc_pkg::OP_PRESS;
                w.button_kind = 2'($urandom_range(0, 2));
                w.button_floor = 4'($urandom_range(0, NFLOORS - 1));
            end else if (roll >= 92) begin
                w.op = ecc_pkg::OP_PRESS;
                if ($urandom_range(0, 1)) begin
                    w.button_kind = KIND_NONE;
                end else begin
                    w.button_kind = 2'($urandom_range(0, 2));
                    w.button_floor = 4'($urandom_range(NFLOORS, 15));
                end
            end
            send_word(w);
        end
    endtask

    task automatic test_output_backpressure();
        sender_gaps_on = 1'b0;
        hold_request = 200;
        press(ecc_pkg::KIND_UP, 4'd2);
        press(ecc_pkg::KIND_CAR, 4'd6);
        press(ecc_pkg::KIND_DOWN, 4'd1);
        tick(27);
        sender_gaps_on = 1'b1;
    endtask

    initial begin
        int drain_wait;
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        model_calls = '0;
        model_floor = 4'd0;
        model_head = ecc_pkg::HEAD_IDLE;
        @(posedge aclk);

        test_ignored_presses();
        test_idle_same_floor();
        test_run_to_top();
        test_reverse_at_floor();
        test_output_backpressure();

        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b1;
        test_random_traffic(250);
        sender_gaps_on = 1'b0;
        receiver_gaps_on = 1'b0;
        test_random_traffic(250);
        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b0;
        test_random_traffic(250);
        sender_gaps_on = 1'b0;
        receiver_gaps_on = 1'b1;
        test_random_traffic(250);

        @(negedge aclk) s_valid <= 1'b0;
        drain_wait = 0;
        while (expected_car_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (4) @(posedge aclk);
        if (expected_car_q.size() != 0) begin
            $display("%0d expected result words never arrived.", expected_car_q.size());
            fault_count += expected_car_q.size();
        end

        $display("Sent %0d words and checked %0d results over %0d cycles, %0d faults.",
                 words_sent, results_checked, cycle_count, fault_count);
        $display("Covered ignored presses, idle service, reversal, long output stall, traffic.");
        if (fault_count == 0) begin
            $display("tb_elevator_collective_control_unit: clean");
        end else begin
            $display("tb_elevator_collective_control_unit: errors");
        end
        $finish;
    end

endmodule

// ===== elevator_collective_control_unit.f =====
rtl/ecc_pkg.sv
rtl/ecc_step.sv
rtl/elevator_collective_control_unit.sv
tb/sv/tb_elevator_collective_control_unit.sv
